### hdl/clcd_pkg.sv
// Shared types, constants and helpers for the character-LCD expander byte writer.
// Used by clcd_front, clcd_queue, clcd_back and the top level; no dependencies.
package clcd_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned BeatsPerReq = 4;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_HOME  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CFG_BACKLIGHT = 3'd0,
    CFG_SELECT    = 3'd1,
    CFG_ENABLE    = 3'd2,
    CFG_LIGHT     = 3'd3,
    CFG_DATA4     = 3'd4,
    CFG_DATA5     = 3'd5,
    CFG_DATA6     = 3'd6,
    CFG_DATA7     = 3'd7
  } cfg_idx_e;

  localparam logic [7:0] GlyphNewline = 8'd10;
  localparam logic [7:0] GlyphReturn  = 8'd13;
  localparam logic [7:0] CmdClear     = 8'h01;
  localparam logic [7:0] CmdHome      = 8'h02;
  localparam logic [1:0] LastBeat     = 2'(BeatsPerReq - 1);

  typedef struct packed {
    logic            backlight;
    logic [2:0]      select_pin;
    logic [2:0]      enable_pin;
    logic [2:0]      light_pin;
    logic [3:0][2:0] data_pin;
  } cfg_t;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
  } entry_t;

  function automatic logic [7:0] line_base(input logic [1:0] line);
    logic [7:0] b;
    unique case (line)
      2'd0: b = 8'h80;
      2'd1: b = 8'hC0;
      2'd2: b = 8'h94;
      default: b = 8'hD4;
    endcase
    return b;
  endfunction

  // beat 0: high nibble + E, 1: high nibble, 2: low nibble + E, 3: low nibble
  function automatic logic [7:0] beat_byte(input entry_t e, input logic [1:0] beat,
                                           input cfg_t cfg);
    logic [3:0] nib;
    logic [7:0] v;
    nib = beat[1] ? e.value[3:0] : e.value[7:4];
    v = 8'h00;
    for (int i = 0; i < 4; i++) begin
      if (nib[i]) v = v | (8'h01 << cfg.data_pin[i]);
    end
    if (e.is_data) v = v | (8'h01 << cfg.select_pin);
    if (cfg.backlight) v = v | (8'h01 << cfg.light_pin);
    if (!beat[0]) v = v | (8'h01 << cfg.enable_pin);
    return v;
  endfunction

endpackage

### hdl/clcd_front.sv
// Request front end: accepts requests, tracks the cursor and forms the LCD byte.
// Depends on clcd_pkg.
module clcd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic [1:0]         req_kind_i,
  input  logic [7:0]         req_glyph_i,
  input  logic [1:0]         req_target_line_i,
  input  logic [7:0]         req_target_column_i,
  output logic               req_ready_o,
  output logic               push_o,
  output clcd_pkg::entry_t   push_entry_o,
  input  logic               queue_full_i
);

  logic [1:0] line_q, line_d;
  logic [7:0] col_q, col_d;
  logic       use_cmd;

  assign req_ready_o = !queue_full_i;
  assign push_o      = req_valid_i && !queue_full_i;

  always_comb begin
    line_d  = line_q;
    col_d   = col_q;
    use_cmd = 1'b1;
    push_entry_o.value   = 8'h00;
    push_entry_o.is_data = 1'b0;
    unique case (clcd_pkg::kind_e'(req_kind_i))
      clcd_pkg::KIND_PUT: begin
        if (req_glyph_i == clcd_pkg::GlyphNewline) begin
          line_d = line_q + 2'd1;
          col_d  = 8'h00;
        end else if (req_glyph_i == clcd_pkg::GlyphReturn) begin
          col_d = 8'h00;
        end else begin
          col_d   = col_q + 8'd1;
          use_cmd = 1'b0;
          push_entry_o.value   = req_glyph_i;
          push_entry_o.is_data = 1'b1;
        end
      end
      clcd_pkg::KIND_MOVE: begin
        line_d = req_target_line_i;
        col_d  = req_target_column_i;
      end
      clcd_pkg::KIND_CLEAR: begin
        line_d  = 2'd0;
        col_d   = 8'h00;
        use_cmd = 1'b0;
        push_entry_o.value = clcd_pkg::CmdClear;
      end
      clcd_pkg::KIND_HOME: begin
        line_d  = 2'd0;
        col_d   = 8'h00;
        use_cmd = 1'b0;
        push_entry_o.value = clcd_pkg::CmdHome;
      end
      default: ;
    endcase
    if (use_cmd) push_entry_o.value = clcd_pkg::line_base(line_d) + col_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= 2'd0;
      col_q  <= 8'h00;
    end else if (push_o) begin
      line_q <= line_d;
      col_q  <= col_d;
    end
  end

endmodule

### hdl/clcd_queue.sv
// Two-entry queue of LCD bytes between the front end and the beat sequencer.
// Depends on clcd_pkg.
module clcd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  clcd_pkg::entry_t push_entry_i,
  output logic             full_o,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output clcd_pkg::entry_t pop_entry_o
);

  localparam int unsigned PtrW = $clog2(clcd_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(clcd_pkg::QueueDepth + 1);

  clcd_pkg::entry_t      mem_q [clcd_pkg::QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       count_q;
  logic                  pop;

  assign full_o      = (count_q == CntW'(clcd_pkg::QueueDepth));
  assign pop_valid_o = (count_q != '0);
  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PtrW'(clcd_pkg::QueueDepth - 1)) ? '0
                                                                           : wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= (rd_ptr_q == PtrW'(clcd_pkg::QueueDepth - 1)) ? '0
                                                                       : rd_ptr_q + 1'b1;
      if (push_i && !pop) count_q <= count_q + 1'b1;
      else if (pop && !push_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_entry_i;
  end

endmodule

### hdl/clcd_back.sv
// Beat sequencer: expands one LCD byte into four expander beats with enable strobes.
// Depends on clcd_pkg.
module clcd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  clcd_pkg::cfg_t   cfg_i,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  clcd_pkg::entry_t pop_entry_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o
);

  clcd_pkg::entry_t entry_q;
  logic [1:0]       beat_q;
  logic             busy_q;
  logic [7:0]       byte_q;
  logic             last_q;
  logic             load, advance;

  assign pop_ready_o = !busy_q || (out_ready_i && beat_q == clcd_pkg::LastBeat);
  assign load        = pop_valid_i && pop_ready_o;
  assign advance     = busy_q && out_ready_i;

  assign out_valid_o = busy_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      beat_q <= 2'd0;
    end else if (load) begin
      busy_q <= 1'b1;
      beat_q <= 2'd0;
    end else if (advance) begin
      if (beat_q == clcd_pkg::LastBeat) busy_q <= 1'b0;
      beat_q <= beat_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_q <= pop_entry_i;
      byte_q  <= clcd_pkg::beat_byte(pop_entry_i, 2'd0, cfg_i);
      last_q  <= 1'b0;
    end else if (advance) begin
      byte_q  <= clcd_pkg::beat_byte(entry_q, beat_q + 2'd1, cfg_i);
      last_q  <= (beat_q + 2'd1 == clcd_pkg::LastBeat);
    end
  end

endmodule

### hdl/char_lcd_expander_byte_stream_top.sv
// Top level of the character-LCD expander byte writer: pin-map registers and wiring.
// Depends on clcd_pkg, clcd_front, clcd_queue, clcd_back.
//
//  channel | dir | handshake                | content
//  s_axis  | in  | tvalid/tready            | one LCD request, kind on tuser
//  m_axis  | out | tvalid/tready, tlast     | one expander byte, tlast on the 4th
//  cfg     | in  | cfg_we_i                 | pin map / backlight register write
//
// Every request yields four output beats, one beat per cycle while the output is
// not stalled; the beat sequencer takes the next byte as the last beat of the one
// before is taken. A request goes through the queue and the beat sequencer's byte
// register to the output; the queue lets the front keep accepting while the output
// stalls. Reset clears cursor and queue and loads the default pin map.
module char_lcd_expander_byte_stream_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // glyph[7:0], target_line[9:8],
                                        // target_column[17:10], zero pad
  input  logic [1:0]  s_axis_tuser_i,   // kind[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // expander_byte[7:0]
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [2:0]  cfg_data_i
);

  clcd_pkg::cfg_t   cfg_q;
  clcd_pkg::entry_t push_entry, pop_entry;
  logic             push, queue_full, pop_valid, pop_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.backlight   <= 1'b1;
      cfg_q.select_pin  <= 3'd0;
      cfg_q.enable_pin  <= 3'd2;
      cfg_q.light_pin   <= 3'd3;
      cfg_q.data_pin[0] <= 3'd4;
      cfg_q.data_pin[1] <= 3'd5;
      cfg_q.data_pin[2] <= 3'd6;
      cfg_q.data_pin[3] <= 3'd7;
    end else if (cfg_we_i) begin
      unique case (clcd_pkg::cfg_idx_e'(cfg_idx_i))
        clcd_pkg::CFG_BACKLIGHT: cfg_q.backlight   <= cfg_data_i[0];
        clcd_pkg::CFG_SELECT:    cfg_q.select_pin  <= cfg_data_i;
        clcd_pkg::CFG_ENABLE:    cfg_q.enable_pin  <= cfg_data_i;
        clcd_pkg::CFG_LIGHT:     cfg_q.light_pin   <= cfg_data_i;
        clcd_pkg::CFG_DATA4:     cfg_q.data_pin[0] <= cfg_data_i;
        clcd_pkg::CFG_DATA5:     cfg_q.data_pin[1] <= cfg_data_i;
        clcd_pkg::CFG_DATA6:     cfg_q.data_pin[2] <= cfg_data_i;
        clcd_pkg::CFG_DATA7:     cfg_q.data_pin[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  clcd_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .req_valid_i         (s_axis_tvalid_i),
    .req_kind_i          (s_axis_tuser_i),
    .req_glyph_i         (s_axis_tdata_i[7:0]),
    .req_target_line_i   (s_axis_tdata_i[9:8]),
    .req_target_column_i (s_axis_tdata_i[17:10]),
    .req_ready_o         (s_axis_tready_o),
    .push_o              (push),
    .push_entry_o        (push_entry),
    .queue_full_i        (queue_full)
  );

  clcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (queue_full),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  clcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

### bench/clcd_beat_checker.sv
// Checker for the character-LCD expander byte writer: predicts the four expander
// beats of every accepted request and compares them with the output stream.
// Depends on clcd_pkg for the request kinds, register indexes and LCD constants.
module clcd_beat_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_tvalid_i,
  input  logic        req_tready_i,
  input  logic [23:0] req_tdata_i,    // glyph[7:0], target_line[9:8],
                                      // target_column[17:10], zero pad
  input  logic [1:0]  req_tuser_i,    // kind[1:0]
  input  logic        beat_tvalid_i,
  input  logic        beat_tready_i,
  input  logic [7:0]  beat_tdata_i,   // expander_byte[7:0]
  input  logic        beat_tlast_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [2:0]  cfg_data_i,
  output int          beats_due_o,
  output int          mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] bits;
    logic       last;
  } beat_t;

  clcd_pkg::cfg_t pin_map;
  logic [1:0]     cur_line;
  logic [7:0]     cur_col;
  beat_t          beats_q[$];
  int             errors;

  function automatic clcd_pkg::cfg_t default_pins();
    clcd_pkg::cfg_t c;
    c.backlight   = 1'b1;
    c.select_pin  = 3'd0;
    c.enable_pin  = 3'd2;
    c.light_pin   = 3'd3;
    c.data_pin[0] = 3'd4;
    c.data_pin[1] = 3'd5;
    c.data_pin[2] = 3'd6;
    c.data_pin[3] = 3'd7;
    return c;
  endfunction

  function automatic logic [7:0] row_address(logic [1:0] line);
    logic [7:0] a;
    case (line)
      2'd0: a = 8'h80;
      2'd1: a = 8'hC0;
      2'd2: a = 8'h94;
      default: a = 8'hD4;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] nibble_pins(logic [3:0] nib, logic rs);
    logic [7:0] v;
    v = 8'h00;
    for (int i = 0; i < 4; i++) begin
      if (nib[i]) v[pin_map.data_pin[i]] = 1'b1;
    end
    if (rs) v[pin_map.select_pin] = 1'b1;
    if (pin_map.backlight) v[pin_map.light_pin] = 1'b1;
    return v;
  endfunction

  task automatic queue_lcd_byte(logic [7:0] value, logic rs);
    logic [7:0] hi, lo, strobe;
    hi = nibble_pins(value[7:4], rs);
    lo = nibble_pins(value[3:0], rs);
    strobe = 8'h00;
    strobe[pin_map.enable_pin] = 1'b1;
    beats_q.push_back('{bits: hi | strobe, last: 1'b0});
    beats_q.push_back('{bits: hi, last: 1'b0});
    beats_q.push_back('{bits: lo | strobe, last: 1'b0});
    beats_q.push_back('{bits: lo, last: 1'b1});
  endtask

  task automatic predict_request(logic [1:0] u, logic [23:0] d);
    clcd_pkg::kind_e kind;
    logic [7:0]      glyph;
    kind  = clcd_pkg::kind_e'(u);
    glyph = d[7:0];
    case (kind)
      clcd_pkg::KIND_PUT: begin
        if (glyph == clcd_pkg::GlyphNewline) begin
          cur_line = cur_line + 2'd1;
          cur_col  = 8'd0;
          queue_lcd_byte(row_address(cur_line) + cur_col, 1'b0);
        end else if (glyph == clcd_pkg::GlyphReturn) begin
          cur_col = 8'd0;
          queue_lcd_byte(row_address(cur_line) + cur_col, 1'b0);
        end else begin
          cur_col = cur_col + 8'd1;
          queue_lcd_byte(glyph, 1'b1);
        end
      end
      clcd_pkg::KIND_MOVE: begin
        cur_line = d[9:8];
        cur_col  = d[17:10];
        queue_lcd_byte(row_address(cur_line) + cur_col, 1'b0);
      end
      clcd_pkg::KIND_CLEAR: begin
        cur_line = 2'd0;
        cur_col  = 8'd0;
        queue_lcd_byte(clcd_pkg::CmdClear, 1'b0);
      end
      clcd_pkg::KIND_HOME: begin
        cur_line = 2'd0;
        cur_col  = 8'd0;
        queue_lcd_byte(clcd_pkg::CmdHome, 1'b0);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t want;
    if (!rst_ni) begin
      pin_map  = default_pins();
      cur_line = 2'd0;
      cur_col  = 8'd0;
      beats_q.delete();
      errors   = 0;
    end else begin
      if (beat_tvalid_i && beat_tready_i) begin
        if (beats_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected beat %h last %b", $realtime, beat_tdata_i, beat_tlast_i);
          end
        end else begin
          want = beats_q.pop_front();
          if (beat_tdata_i !== want.bits) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: expander byte expected %h got %h", $realtime, want.bits,
                       beat_tdata_i);
            end
          end
          if (beat_tlast_i !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: tlast expected %b got %b", $realtime, want.last, beat_tlast_i);
            end
          end
        end
      end
      if (req_tvalid_i && req_tready_i) predict_request(req_tuser_i, req_tdata_i);
      if (cfg_we_i) begin
        case (clcd_pkg::cfg_idx_e'(cfg_idx_i))
          clcd_pkg::CFG_BACKLIGHT: pin_map.backlight   = cfg_data_i[0];
          clcd_pkg::CFG_SELECT:    pin_map.select_pin  = cfg_data_i;
          clcd_pkg::CFG_ENABLE:    pin_map.enable_pin  = cfg_data_i;
          clcd_pkg::CFG_LIGHT:     pin_map.light_pin   = cfg_data_i;
          clcd_pkg::CFG_DATA4:     pin_map.data_pin[0] = cfg_data_i;
          clcd_pkg::CFG_DATA5:     pin_map.data_pin[1] = cfg_data_i;
          clcd_pkg::CFG_DATA6:     pin_map.data_pin[2] = cfg_data_i;
          clcd_pkg::CFG_DATA7:     pin_map.data_pin[3] = cfg_data_i;
        endcase
      end
    end
    beats_due_o  <= beats_q.size();
    mismatches_o <= errors;
  end

endmodule

### bench/char_lcd_expander_byte_stream_top_tb.sv
// Testbench top for the character-LCD expander byte writer: drives requests,
// pin-map writes and output back-pressure; clcd_beat_checker does the checking.
// Depends on clcd_pkg, char_lcd_expander_byte_stream_top and clcd_beat_checker.
module char_lcd_expander_byte_stream_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 200;
  localparam int CfgW       = $bits(clcd_pkg::cfg_t);

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [2:0]  cfg_data = '0;
  int          beats_due;
  int          mismatches;
  bit          idle_on = 1'b1;
  bit          hold_beats = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  char_lcd_expander_byte_stream_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  clcd_beat_checker i_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_tvalid_i  (s_tvalid),
    .req_tready_i  (s_tready),
    .req_tdata_i   (s_tdata),
    .req_tuser_i   (s_tuser),
    .beat_tvalid_i (m_tvalid),
    .beat_tready_i (m_tready),
    .beat_tdata_i  (m_tdata),
    .beat_tlast_i  (m_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .beats_due_o   (beats_due),
    .mismatches_o  (mismatches)
  );

  task automatic send_req(clcd_pkg::kind_e k, logic [7:0] g, logic [1:0] ln, logic [7:0] col);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {6'h00, col, ln, g};
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic run_random(int n);
    int              r;
    clcd_pkg::kind_e k;
    logic [7:0]      g;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      k = (r < 50) ? clcd_pkg::KIND_PUT : (r < 75) ? clcd_pkg::KIND_MOVE :
          (r < 88) ? clcd_pkg::KIND_CLEAR : clcd_pkg::KIND_HOME;
      g = 8'($urandom());
      if (k == clcd_pkg::KIND_PUT && $urandom_range(0, 4) == 0) begin
        g = $urandom_range(0, 1) ? clcd_pkg::GlyphNewline : clcd_pkg::GlyphReturn;
      end
      send_req(k, g, 2'($urandom()), 8'($urandom()));
    end
  endtask

  // drain all beats, then give the pipeline time to go idle
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (beats_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_pins(clcd_pkg::cfg_t c);
    clcd_pkg::cfg_idx_e idx;
    idx = idx.first();
    repeat (8) begin
      cfg_we  <= 1'b1;
      cfg_idx <= idx;
      case (idx)
        clcd_pkg::CFG_BACKLIGHT: cfg_data <= {2'b00, c.backlight};
        clcd_pkg::CFG_SELECT:    cfg_data <= c.select_pin;
        clcd_pkg::CFG_ENABLE:    cfg_data <= c.enable_pin;
        clcd_pkg::CFG_LIGHT:     cfg_data <= c.light_pin;
        clcd_pkg::CFG_DATA4:     cfg_data <= c.data_pin[0];
        clcd_pkg::CFG_DATA5:     cfg_data <= c.data_pin[1];
        clcd_pkg::CFG_DATA6:     cfg_data <= c.data_pin[2];
        clcd_pkg::CFG_DATA7:     cfg_data <= c.data_pin[3];
      endcase
      @(posedge clk_i);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
  endtask

  function automatic clcd_pkg::cfg_t rand_pins();
    clcd_pkg::cfg_t c;
    c = clcd_pkg::cfg_t'(CfgW'($urandom()));
    c.backlight = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // output back-pressure
  initial begin
    forever begin
      if (hold_beats) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_beats = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    clcd_pkg::cfg_t c;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset pin map
    send_req(clcd_pkg::KIND_PUT, 8'h41, 2'd0, 8'd0);
    send_req(clcd_pkg::KIND_PUT, 8'h00, 2'd3, 8'hFF);
    send_req(clcd_pkg::KIND_PUT, 8'hFF, 2'd0, 8'd0);
    repeat (4) send_req(clcd_pkg::KIND_PUT, clcd_pkg::GlyphNewline, 2'd0, 8'd0);
    send_req(clcd_pkg::KIND_PUT, clcd_pkg::GlyphReturn, 2'd2, 8'h55);
    send_req(clcd_pkg::KIND_MOVE, 8'hFF, 2'd3, 8'hFF);
    send_req(clcd_pkg::KIND_MOVE, 8'h00, 2'd1, 8'h40);
    send_req(clcd_pkg::KIND_MOVE, 8'h00, 2'd0, 8'h00);
    send_req(clcd_pkg::KIND_MOVE, 8'h00, 2'd2, 8'hFF);
    send_req(clcd_pkg::KIND_PUT, 8'h7E, 2'd0, 8'd0);
    send_req(clcd_pkg::KIND_PUT, clcd_pkg::GlyphReturn, 2'd0, 8'd0);
    send_req(clcd_pkg::KIND_CLEAR, 8'hFF, 2'd3, 8'hFF);
    send_req(clcd_pkg::KIND_PUT, clcd_pkg::GlyphNewline, 2'd0, 8'd0);
    send_req(clcd_pkg::KIND_HOME, clcd_pkg::GlyphNewline, 2'd2, 8'hAA);
    send_req(clcd_pkg::KIND_PUT, clcd_pkg::GlyphReturn, 2'd0, 8'd0);
    send_req(clcd_pkg::KIND_MOVE, 8'h00, 2'd3, 8'h00);
    send_req(clcd_pkg::KIND_PUT, clcd_pkg::GlyphNewline, 2'd0, 8'd0);
    send_req(clcd_pkg::KIND_HOME, 8'h00, 2'd0, 8'h00);

    // everything on bit 0, backlight off
    settle();
    c = '0;
    load_pins(c);
    run_random(40);

    // everything on bit 7; outputs held off while requests pile up
    settle();
    c = '1;
    load_pins(c);
    hold_beats = 1'b1;
    run_random(60);

    repeat (4) begin
      settle();
      load_pins(rand_pins());
      run_random(80);
    end

    // back to the default map, no idling
    settle();
    idle_on = 1'b0;
    c.backlight   = 1'b1;
    c.select_pin  = 3'd0;
    c.enable_pin  = 3'd2;
    c.light_pin   = 3'd3;
    c.data_pin[0] = 3'd4;
    c.data_pin[1] = 3'd5;
    c.data_pin[2] = 3'd6;
    c.data_pin[3] = 3'd7;
    load_pins(c);
    run_random(60);

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && beats_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
hdl/clcd_pkg.sv
hdl/clcd_front.sv
hdl/clcd_queue.sv
hdl/clcd_back.sv
hdl/char_lcd_expander_byte_stream_top.sv
bench/clcd_beat_checker.sv
bench/char_lcd_expander_byte_stream_top_tb.sv
